// ----- rtl/tvag_pkg.sv -----
// Shared constants and types for the torus vertex attribute generator.
// Used by the top level, front end, back end and testbench; depends on nothing else.
package tvag_pkg;

	// Default geometry and number format.
	localparam int SINE_TABLE_DEPTH = 1024;
	localparam int FRACTION_BITS = 14;

	// Largest segment count honored; larger settings are clamped to it.
	localparam int MAX_SEGMENTS = 255;

	// pi/2 in Q30, the seed for the quarter-wave sine table.
	localparam longint unsigned Q30_HALF_PI = 64'd1686629713;

	// Configuration register indexes (byte address is four times the index).
	localparam logic [1:0] REG_POINT_COUNT = 2'd0;
	localparam logic [1:0] REG_MAJOR_RADIUS = 2'd1;
	localparam logic [1:0] REG_TUBE_RADIUS = 2'd2;

	// Register reset values.
	localparam logic [7:0] POINT_COUNT_RESET = 8'd48;
	localparam logic [15:0] MAJOR_RADIUS_RESET = 16'd8192;
	localparam logic [15:0] TUBE_RADIUS_RESET = 16'd3277;

	// Width of one packed result: kind, three components, last and error flags.
	localparam int RESULT_WIDTH = 3 + 3 * 20 + 2;

	typedef enum logic [2:0] {
		KIND_POSITION = 3'd0,
		KIND_NORMAL = 3'd1,
		KIND_S_TANGENT = 3'd2,
		KIND_T_TANGENT = 3'd3,
		KIND_TEXCOORD = 3'd4
	} attr_kind_t;

endpackage

// ----- rtl/torus_vertex_attribute_generator_top.sv -----
// Top level of the torus vertex attribute generator: configuration registers,
// front end, middle queue, back end and result queue. Depends on tvag_pkg and all modules.
//
// Channel   Direction  Handshake               Payload
// config    in         psel/penable/pwrite     paddr, pwdata, prdata (APB, pready tied high)
// request   in         push / full             ring_index, vertex_index
// result    out        empty / pop             attribute_kind, value_x/y/z, last_of_vertex,
//                                              index_error
//
// A valid request gives five results from the back end, whose fixed schedule on two shared
// multipliers and a two-port sine ROM sets the rate: it takes the next request only after the fifth result.
// The front end's divider works on the next request meanwhile, so the two overlap.
// An out-of-range request gives one error result, pushed straight from the back end's idle state.
// Reset sets the registers to 48, 8192 and 3277 and empties both queues; no clearing pass.
// A full result queue stalls the back end, and a full middle queue stalls the front end.
module torus_vertex_attribute_generator_top #(
	parameter int SINE_TABLE_DEPTH = tvag_pkg::SINE_TABLE_DEPTH,
	parameter int FRACTION_BITS = tvag_pkg::FRACTION_BITS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [3:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               push,
	output logic               full,
	input  logic [7:0]         ring_index,
	input  logic [7:0]         vertex_index,
	output logic               empty,
	input  logic               pop,
	output logic [2:0]         attribute_kind,
	output logic signed [19:0] value_x,
	output logic signed [19:0] value_y,
	output logic signed [19:0] value_z,
	output logic               last_of_vertex,
	output logic               index_error
);

	localparam int LD = $clog2(SINE_TABLE_DEPTH);
	localparam int EW = 1 + 2 * (LD + 2) + 2 * (FRACTION_BITS + 1);

	logic [7:0] point_count_q;
	logic [15:0] major_radius_q;
	logic [15:0] tube_radius_q;
	logic cfg_write;

	logic mid_push;
	logic mid_full;
	logic mid_pop;
	logic mid_empty;
	logic [EW-1:0] mid_wdata;
	logic [EW-1:0] mid_rdata;
	logic out_push;
	logic out_full;
	logic [tvag_pkg::RESULT_WIDTH-1:0] out_wdata;
	logic [tvag_pkg::RESULT_WIDTH-1:0] out_rdata;

	// Configuration registers.
	assign pready = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			point_count_q <= tvag_pkg::POINT_COUNT_RESET;
			major_radius_q <= tvag_pkg::MAJOR_RADIUS_RESET;
			tube_radius_q <= tvag_pkg::TUBE_RADIUS_RESET;
		end else if (cfg_write) begin
			unique case (paddr[3:2])
				tvag_pkg::REG_POINT_COUNT: point_count_q <= pwdata[7:0];
				tvag_pkg::REG_MAJOR_RADIUS: major_radius_q <= pwdata[15:0];
				tvag_pkg::REG_TUBE_RADIUS: tube_radius_q <= pwdata[15:0];
				default: point_count_q <= point_count_q;
			endcase
		end
	end

	// Register read back.
	always_comb begin
		unique case (paddr[3:2])
			tvag_pkg::REG_POINT_COUNT: prdata = {24'd0, point_count_q};
			tvag_pkg::REG_MAJOR_RADIUS: prdata = {16'd0, major_radius_q};
			tvag_pkg::REG_TUBE_RADIUS: prdata = {16'd0, tube_radius_q};
			default: prdata = '0;
		endcase
	end

	tvag_front #(
		.SINE_TABLE_DEPTH(SINE_TABLE_DEPTH),
		.FRACTION_BITS(FRACTION_BITS)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.ring_index(ring_index),
		.vertex_index(vertex_index),
		.point_count(point_count_q),
		.mid_push(mid_push),
		.mid_data(mid_wdata),
		.mid_full(mid_full)
	);

	tvag_fifo #(
		.WIDTH(EW),
		.DEPTH(2)
	) u_mid_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(mid_push),
		.wdata(mid_wdata),
		.full(mid_full),
		.pop(mid_pop),
		.rdata(mid_rdata),
		.empty(mid_empty)
	);

	tvag_back #(
		.SINE_TABLE_DEPTH(SINE_TABLE_DEPTH),
		.FRACTION_BITS(FRACTION_BITS)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.mid_data(mid_rdata),
		.mid_empty(mid_empty),
		.mid_pop(mid_pop),
		.major_radius(major_radius_q),
		.tube_radius(tube_radius_q),
		.out_push(out_push),
		.out_data(out_wdata),
		.out_full(out_full)
	);

	tvag_fifo #(
		.WIDTH(tvag_pkg::RESULT_WIDTH),
		.DEPTH(4)
	) u_out_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(out_push),
		.wdata(out_wdata),
		.full(out_full),
		.pop(pop),
		.rdata(out_rdata),
		.empty(empty)
	);

	// Result fields.
	assign attribute_kind = out_rdata[64:62];
	assign value_x = out_rdata[61:42];
	assign value_y = out_rdata[41:22];
	assign value_z = out_rdata[21:2];
	assign last_of_vertex = out_rdata[1];
	assign index_error = out_rdata[0];

endmodule

// ----- rtl/tvag_fifo.sv -----
// Small register queue used between the front and back ends and at the output.
// Depends on nothing else; DEPTH must be a power of two of at least two.
module tvag_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int AW = $clog2(DEPTH);

	logic [WIDTH-1:0] slots_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [AW:0] count_q;
	logic do_push;
	logic do_pop;

	// Status and read side.
	assign full = (count_q == (AW+1)'(DEPTH));
	assign empty = (count_q == '0);
	assign rdata = slots_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop = pop && !empty;

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			slots_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

// ----- rtl/tvag_front.sv -----
// Front end: takes a ring and vertex index, checks them and finds both angle
// fractions with a four-bit-per-cycle divider. Depends on tvag_pkg.
module tvag_front #(
	parameter int SINE_TABLE_DEPTH = tvag_pkg::SINE_TABLE_DEPTH,
	parameter int FRACTION_BITS = tvag_pkg::FRACTION_BITS,
	localparam int LD = $clog2(SINE_TABLE_DEPTH),
	localparam int SW = LD + 2,
	localparam int FW = FRACTION_BITS + 1,
	localparam int EW = 1 + 2 * SW + 2 * FW
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	output logic          full,
	input  logic [7:0]    ring_index,
	input  logic [7:0]    vertex_index,
	input  logic [7:0]    point_count,
	output logic          mid_push,
	output logic [EW-1:0] mid_data,
	input  logic          mid_full
);

	// The quotient carries W fraction bits, enough to round at every scale used.
	localparam int WB = (FRACTION_BITS + 2 > LD + 3) ? FRACTION_BITS + 2 : LD + 3;
	localparam int W = ((WB + 3) / 4) * 4;
	localparam int DIV_CYCLES = W / 4;
	localparam int CW = $clog2(DIV_CYCLES + 1);
	localparam int SH_A = W - LD - 2;
	localparam int SH_T = W - FRACTION_BITS;
	localparam int SH_S = W - FRACTION_BITS - 1;

	typedef enum logic [2:0] {
		F_IDLE = 3'b001,
		F_DIV  = 3'b010,
		F_PUSH = 3'b100
	} fstate_t;

	fstate_t state_q;
	logic in_valid_q;
	logic [7:0] ring_q;
	logic [7:0] vert_q;
	logic err_q;
	logic ring_gt_q;
	logic [7:0] prec_q;
	logic [CW-1:0] cnt_q;
	logic [W:0] qv_q;
	logic [W:0] qr_q;
	logic [7:0] remv_q;
	logic [7:0] remr_q;

	logic start;
	logic accept;
	logic [7:0] prec;
	logic bad;
	logic [W:0] qv_nx;
	logic [W:0] qr_nx;
	logic [7:0] remv_nx;
	logic [7:0] remr_nx;
	logic [W+1:0] sum_a;
	logic [W+1:0] sum_b;
	logic [W+1:0] sum_t;
	logic [W+1:0] sum_s;
	logic [FW:0] ts_raw;
	logic [FW-1:0] ts;

	// Input holding register: a new item waits here while the divider runs.
	assign start = (state_q == F_IDLE) && in_valid_q;
	assign full = in_valid_q && !start;
	assign accept = push && !full;

	// Segment count clamped to the supported maximum, and the index check.
	always_comb begin
		prec = (32'(point_count) > tvag_pkg::MAX_SEGMENTS) ?
			8'(tvag_pkg::MAX_SEGMENTS) : point_count;
		bad = (prec == '0) || (ring_q > prec) || (vert_q > prec);
	end

	// Four restoring division steps per cycle on both quotients.
	always_comb begin
		logic [8:0] tv;
		logic [8:0] tr;
		qv_nx = qv_q;
		qr_nx = qr_q;
		remv_nx = remv_q;
		remr_nx = remr_q;
		for (int i = 0; i < 4; i++) begin
			tv = {remv_nx, 1'b0};
			tr = {remr_nx, 1'b0};
			qv_nx = {qv_nx[W-1:0], tv >= {1'b0, prec_q}};
			qr_nx = {qr_nx[W-1:0], tr >= {1'b0, prec_q}};
			if (tv >= {1'b0, prec_q}) begin
				tv = tv - {1'b0, prec_q};
			end
			if (tr >= {1'b0, prec_q}) begin
				tr = tr - {1'b0, prec_q};
			end
			remv_nx = tv[7:0];
			remr_nx = tr[7:0];
		end
	end

	// Round the fine quotients to the table step and texture scales.
	always_comb begin
		sum_a = {1'b0, qv_q} + (W+2)'(1 << (SH_A - 1));
		sum_b = {1'b0, qr_q} + (W+2)'(1 << (SH_A - 1));
		sum_t = {1'b0, qv_q} + (W+2)'(1 << (SH_T - 1));
		sum_s = {1'b0, qr_q} + (W+2)'(1 << (SH_S - 1));
		ts_raw = sum_s[SH_S +: FW+1];
		if (ring_gt_q) begin
			ts_raw = ts_raw - (FW+1)'(1 << FRACTION_BITS);
		end
		ts = ts_raw[FW-1:0];
		mid_push = (state_q == F_PUSH) && !mid_full;
		if (err_q) begin
			mid_data = {1'b1, (EW-1)'(0)};
		end else begin
			mid_data = {1'b0, sum_a[SH_A +: SW], sum_b[SH_A +: SW], ts, sum_t[SH_T +: FW]};
		end
	end

	// Control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			in_valid_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			in_valid_q <= accept || (in_valid_q && !start);
			unique case (state_q)
				F_IDLE: begin
					cnt_q <= '0;
					if (start) begin
						state_q <= bad ? F_PUSH : F_DIV;
					end
				end
				F_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CW'(DIV_CYCLES - 1)) begin
						state_q <= F_PUSH;
					end
				end
				F_PUSH: begin
					if (!mid_full) begin
						state_q <= F_IDLE;
					end
				end
				default: begin
					state_q <= F_IDLE;
				end
			endcase
		end
	end

	// Datapath.
	always_ff @(posedge clk) begin
		if (accept) begin
			ring_q <= ring_index;
			vert_q <= vertex_index;
		end
		if (start) begin
			err_q <= bad;
			prec_q <= prec;
			ring_gt_q <= {ring_q, 1'b0} > {1'b0, prec};
			qv_q <= (W+1)'(vert_q == prec);
			qr_q <= (W+1)'(ring_q == prec);
			remv_q <= (vert_q == prec) ? 8'd0 : vert_q;
			remr_q <= (ring_q == prec) ? 8'd0 : ring_q;
		end else if (state_q == F_DIV) begin
			qv_q <= qv_nx;
			qr_q <= qr_nx;
			remv_q <= remv_nx;
			remr_q <= remr_nx;
		end
	end

endmodule

// ----- rtl/tvag_back.sv -----
// Back end: looks up sine and cosine in a quarter-wave ROM, forms the products
// on two shared multipliers and emits the five results, or one error result. Depends on tvag_pkg.
module tvag_back #(
	parameter int SINE_TABLE_DEPTH = tvag_pkg::SINE_TABLE_DEPTH,
	parameter int FRACTION_BITS = tvag_pkg::FRACTION_BITS,
	localparam int LD = $clog2(SINE_TABLE_DEPTH),
	localparam int SW = LD + 2,
	localparam int FW = FRACTION_BITS + 1,
	localparam int EW = 1 + 2 * SW + 2 * FW
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic [EW-1:0]                     mid_data,
	input  logic                              mid_empty,
	output logic                              mid_pop,
	input  logic [15:0]                       major_radius,
	input  logic [15:0]                       tube_radius,
	output logic                              out_push,
	output logic [tvag_pkg::RESULT_WIDTH-1:0] out_data,
	input  logic                              out_full
);

	localparam int MW = (FRACTION_BITS + 2 > 19) ? FRACTION_BITS + 2 : 19;
	localparam longint unsigned HALF = 64'd1 << (FRACTION_BITS - 1);

	typedef logic [FRACTION_BITS:0] rom_t [0:SINE_TABLE_DEPTH];

	typedef enum logic [8:0] {
		B_IDLE = 9'b000000001,
		B_T1   = 9'b000000010,
		B_T2   = 9'b000000100,
		B_T3   = 9'b000001000,
		B_POS  = 9'b000010000,
		B_NRM  = 9'b000100000,
		B_STAN = 9'b001000000,
		B_TTAN = 9'b010000000,
		B_TEX  = 9'b100000000
	} bstate_t;

	// Quarter-wave sine table, sin(pi/2 k/DEPTH) by a Q30 Taylor series.
	function automatic rom_t build_rom();
		rom_t t;
		longint unsigned x;
		longint unsigned x2;
		longint unsigned term;
		longint unsigned sum;
		longint unsigned v;
		for (int k = 0; k <= SINE_TABLE_DEPTH; k++) begin
			x = (longint'(k) * tvag_pkg::Q30_HALF_PI) / SINE_TABLE_DEPTH;
			x2 = (x * x) >> 30;
			term = x;
			sum = x;
			// Twelve series terms; term n is divided by (2n)(2n+1).
			term = ((term * x2) >> 30) / 64'd6;
			sum = sum - term;
			term = ((term * x2) >> 30) / 64'd20;
			sum = sum + term;
			term = ((term * x2) >> 30) / 64'd42;
			sum = sum - term;
			term = ((term * x2) >> 30) / 64'd72;
			sum = sum + term;
			term = ((term * x2) >> 30) / 64'd110;
			sum = sum - term;
			term = ((term * x2) >> 30) / 64'd156;
			sum = sum + term;
			term = ((term * x2) >> 30) / 64'd210;
			sum = sum - term;
			term = ((term * x2) >> 30) / 64'd272;
			sum = sum + term;
			term = ((term * x2) >> 30) / 64'd342;
			sum = sum - term;
			term = ((term * x2) >> 30) / 64'd420;
			sum = sum + term;
			term = ((term * x2) >> 30) / 64'd506;
			sum = sum - term;
			term = ((term * x2) >> 30) / 64'd600;
			sum = sum + term;
			v = (sum + (64'd1 << (29 - FRACTION_BITS))) >> (30 - FRACTION_BITS);
			if (v > (64'd1 << FRACTION_BITS)) begin
				v = 64'd1 << FRACTION_BITS;
			end
			t[k] = v[FRACTION_BITS:0];
		end
		return t;
	endfunction

	localparam rom_t SINE_ROM = build_rom();

	// Fixed-point product, rounded half away from zero.
	function automatic logic signed [MW-1:0] fx_mul(input logic signed [MW-1:0] a,
			input logic signed [MW-1:0] b);
		logic [MW-1:0] ma;
		logic [MW-1:0] mb;
		logic [2*MW-1:0] m;
		ma = a[MW-1] ? MW'(-a) : MW'(a);
		mb = b[MW-1] ? MW'(-b) : MW'(b);
		m = (2*MW)'(ma) * (2*MW)'(mb);
		m = (m + (2*MW)'(HALF)) >> FRACTION_BITS;
		return (a[MW-1] ^ b[MW-1]) ? -$signed(m[MW-1:0]) : $signed(m[MW-1:0]);
	endfunction

	// Clamp to the signed 20-bit result range.
	function automatic logic [19:0] sat20(input logic signed [MW-1:0] v);
		logic signed [31:0] w;
		w = $signed({{(32 - MW){v[MW-1]}}, v});
		if (w > 32'sd524287) begin
			w = 32'sd524287;
		end else if (w < -32'sd524288) begin
			w = -32'sd524288;
		end
		return w[19:0];
	endfunction

	function automatic logic [tvag_pkg::RESULT_WIDTH-1:0] pack(input tvag_pkg::attr_kind_t kind,
			input logic signed [MW-1:0] x, input logic signed [MW-1:0] y,
			input logic signed [MW-1:0] z, input logic last, input logic err);
		return {kind, sat20(x), sat20(y), sat20(z), last, err};
	endfunction

	bstate_t state_q;
	logic [SW-1:0] sb_step_q;
	logic [FW-1:0] ts_q;
	logic [FW-1:0] tt_q;
	logic [FRACTION_BITS:0] rom_a_q;
	logic [FRACTION_BITS:0] rom_b_q;
	logic neg_a_q;
	logic neg_b_q;
	logic signed [MW-1:0] sa_q, ca_q, sb_q, cb_q;
	logic signed [MW-1:0] m1_q, m2_q;
	logic signed [MW-1:0] p_q, posy_q, nx_q, nz_q, tx_q, tz_q;

	logic head_err;
	logic [SW-1:0] step;
	logic [1:0] qs;
	logic [1:0] qc;
	logic [LD:0] idx_a;
	logic [LD:0] idx_b;
	logic signed [MW-1:0] sv_a;
	logic signed [MW-1:0] sv_b;
	logic signed [MW-1:0] r_s;
	logic signed [MW-1:0] big_r;
	logic adv;

	assign head_err = mid_data[EW-1];
	assign r_s = $signed(MW'(tube_radius));
	assign big_r = $signed(MW'(major_radius));

	// ROM addresses: port A reads the sine, port B the cosine of one angle.
	always_comb begin
		step = (state_q == B_IDLE) ? mid_data[EW-2 -: SW] : sb_step_q;
		qs = step[SW-1:LD];
		qc = qs + 2'd1;
		idx_a = qs[0] ? (LD+1)'(SINE_TABLE_DEPTH) - {1'b0, step[LD-1:0]} : {1'b0, step[LD-1:0]};
		idx_b = qc[0] ? (LD+1)'(SINE_TABLE_DEPTH) - {1'b0, step[LD-1:0]} : {1'b0, step[LD-1:0]};
		sv_a = neg_a_q ? -$signed(MW'(rom_a_q)) : $signed(MW'(rom_a_q));
		sv_b = neg_b_q ? -$signed(MW'(rom_b_q)) : $signed(MW'(rom_b_q));
	end

	// Result selection and handshakes with both queues.
	always_comb begin
		mid_pop = 1'b0;
		out_push = 1'b0;
		out_data = '0;
		adv = 1'b1;
		unique case (state_q)
			B_IDLE: begin
				if (!mid_empty) begin
					if (head_err) begin
						mid_pop = !out_full;
						out_push = !out_full;
						out_data = pack(tvag_pkg::KIND_POSITION, '0, '0, '0, 1'b1, 1'b1);
					end else begin
						mid_pop = 1'b1;
					end
				end
			end
			B_POS: begin
				out_push = !out_full;
				out_data = pack(tvag_pkg::KIND_POSITION, m1_q, posy_q, -m2_q, 1'b0, 1'b0);
			end
			B_NRM: begin
				out_push = !out_full;
				out_data = pack(tvag_pkg::KIND_NORMAL, nx_q, sa_q, nz_q, 1'b0, 1'b0);
			end
			B_STAN: begin
				out_push = !out_full;
				out_data = pack(tvag_pkg::KIND_S_TANGENT, -sb_q, '0, -cb_q, 1'b0, 1'b0);
			end
			B_TTAN: begin
				out_push = !out_full;
				out_data = pack(tvag_pkg::KIND_T_TANGENT, tx_q, -ca_q, tz_q, 1'b0, 1'b0);
			end
			B_TEX: begin
				out_push = !out_full;
				out_data = pack(tvag_pkg::KIND_TEXCOORD, $signed(MW'(ts_q)),
					$signed(MW'(tt_q)), '0, 1'b1, 1'b0);
			end
			default: begin
				adv = 1'b1;
			end
		endcase
		if (state_q == B_POS || state_q == B_NRM || state_q == B_STAN ||
				state_q == B_TTAN || state_q == B_TEX) begin
			adv = !out_full;
		end
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
		end else if (adv) begin
			unique case (state_q)
				B_IDLE: state_q <= (mid_pop && !head_err) ? B_T1 : B_IDLE;
				B_T1: state_q <= B_T2;
				B_T2: state_q <= B_T3;
				B_T3: state_q <= B_POS;
				B_POS: state_q <= B_NRM;
				B_NRM: state_q <= B_STAN;
				B_STAN: state_q <= B_TTAN;
				B_TTAN: state_q <= B_TEX;
				B_TEX: state_q <= B_IDLE;
				default: state_q <= B_IDLE;
			endcase
		end
	end

	// ROM read ports.
	always_ff @(posedge clk) begin
		rom_a_q <= SINE_ROM[idx_a];
		rom_b_q <= SINE_ROM[idx_b];
		neg_a_q <= qs[1];
		neg_b_q <= qc[1];
	end

	// Operand registers and the two multipliers.
	always_ff @(posedge clk) begin
		if (adv) begin
			unique case (state_q)
				B_IDLE: begin
					sb_step_q <= mid_data[EW-2-SW -: SW];
					ts_q <= mid_data[2*FW-1 -: FW];
					tt_q <= mid_data[FW-1:0];
				end
				B_T1: begin
					sa_q <= sv_a;
					ca_q <= sv_b;
					m1_q <= fx_mul(r_s, sv_b);
					m2_q <= fx_mul(r_s, sv_a);
				end
				B_T2: begin
					sb_q <= sv_a;
					cb_q <= sv_b;
					p_q <= big_r + m1_q;
					posy_q <= m2_q;
					m1_q <= fx_mul(ca_q, sv_b);
					m2_q <= fx_mul(ca_q, sv_a);
				end
				B_T3: begin
					nx_q <= m1_q;
					nz_q <= -m2_q;
					m1_q <= fx_mul(p_q, cb_q);
					m2_q <= fx_mul(p_q, sb_q);
				end
				B_POS: begin
					m1_q <= fx_mul(sa_q, cb_q);
					m2_q <= fx_mul(sa_q, sb_q);
				end
				B_NRM: begin
					tx_q <= m1_q;
					tz_q <= -m2_q;
				end
				default: begin
					tx_q <= tx_q;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	// A result is never written into a full output queue.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		out_push |-> !out_full) else $error("result written into full queue");

	// An item is only taken from the middle queue when one is there.
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		mid_pop |-> !mid_empty) else $error("item taken from empty queue");

	// An error result always closes its item.
	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_push && out_data[0]) |-> out_data[1]) else $error("error result not last");
`endif

endmodule

// ----- test/tb.sv -----
// Self-checking testbench for the torus vertex attribute generator top level.
// Depends on tvag_pkg and torus_vertex_attribute_generator_top; predicts every attribute item.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SINE_TABLE_DEPTH = tvag_pkg::SINE_TABLE_DEPTH;
	localparam int FRACTION_BITS = tvag_pkg::FRACTION_BITS;
	localparam int MAX_SEGMENTS = tvag_pkg::MAX_SEGMENTS;
	localparam longint unsigned Q30_HALF_PI = tvag_pkg::Q30_HALF_PI;

	typedef struct {
		logic [7:0] ring;
		logic [7:0] vert;
	} vertex_req_t;

	typedef struct {
		tvag_pkg::attr_kind_t kind;
		logic signed [19:0] x;
		logic signed [19:0] y;
		logic signed [19:0] z;
		logic last;
		logic err;
	} attr_item_t;

	logic clk, arst_n;
	logic psel, penable, pwrite;
	logic [3:0] paddr;
	logic [31:0] pwdata, prdata;
	logic pready;
	logic push, full, empty, pop;
	logic [7:0] ring_index, vertex_index;
	logic [2:0] attribute_kind;
	logic signed [19:0] value_x, value_y, value_z;
	logic last_of_vertex, index_error;

	torus_vertex_attribute_generator_top u_top (.*);

	// Testbench copy of the register file and sine table.
	logic [7:0] cur_points;
	logic [15:0] cur_major;
	logic [15:0] cur_tube;
	longint quarter_sine[SINE_TABLE_DEPTH + 1];

	vertex_req_t pending_reqs[$];
	attr_item_t expected_attrs[$];
	int mismatches = 0;
	longint cycle_count = 0;
	bit feed_paused = 0;
	bit idle_free = 0;

	// Clock.
	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > 400000) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	function automatic void build_sine();
		longint unsigned x, x2, term, sum, v;
		for (int k = 0; k <= SINE_TABLE_DEPTH; k++) begin
			x = (longint'(k) * Q30_HALF_PI) / SINE_TABLE_DEPTH;
			x2 = (x * x) >> 30;
			term = x;
			sum = x;
			for (int n = 1; n <= 12; n++) begin
				term = ((term * x2) >> 30) / ((2 * n) * (2 * n + 1));
				if (n & 1) sum -= term;
				else sum += term;
			end
			v = (sum + (64'd1 << (29 - FRACTION_BITS))) >> (30 - FRACTION_BITS);
			if (v > (64'd1 << FRACTION_BITS)) v = 64'd1 << FRACTION_BITS;
			quarter_sine[k] = v;
		end
	endfunction

	function automatic longint sine_of(longint unsigned step);
		longint unsigned q, r;
		longint v;
		step = step % (4 * SINE_TABLE_DEPTH);
		q = step / SINE_TABLE_DEPTH;
		r = step % SINE_TABLE_DEPTH;
		v = q[0] ? quarter_sine[SINE_TABLE_DEPTH - r] : quarter_sine[r];
		return (q >= 2) ? -v : v;
	endfunction

	// Fixed-point product, rounded half away from zero.
	function automatic longint qmul(longint a, longint b);
		longint unsigned ma, mb, m;
		ma = (a < 0) ? -a : a;
		mb = (b < 0) ? -b : b;
		m = (ma * mb + (64'd1 << (FRACTION_BITS - 1))) >> FRACTION_BITS;
		return ((a < 0) != (b < 0)) ? -longint'(m) : longint'(m);
	endfunction

	function automatic logic signed [19:0] clamp20(longint v);
		if (v > 524287) v = 524287;
		if (v < -524288) v = -524288;
		return v[19:0];
	endfunction

	function automatic void add_attr(tvag_pkg::attr_kind_t k, longint x, longint y, longint z,
			logic last, logic err);
		attr_item_t a;
		a.kind = k;
		a.x = clamp20(x);
		a.y = clamp20(y);
		a.z = clamp20(z);
		a.last = last;
		a.err = err;
		expected_attrs.push_back(a);
	endfunction

	// Expected attribute items of one vertex request.
	function automatic void predict_vertex(vertex_req_t rq);
		longint unsigned prec, full_turn, one, sa_step, sb_step;
		longint unsigned ring, vert;
		longint sa, ca, sb, cb, p, ts, tt;
		ring = rq.ring;
		vert = rq.vert;
		prec = cur_points;
		full_turn = 4 * SINE_TABLE_DEPTH;
		one = 64'd1 << FRACTION_BITS;
		if (prec > MAX_SEGMENTS) prec = MAX_SEGMENTS;
		if (prec == 0 || ring > prec || vert > prec) begin
			add_attr(tvag_pkg::KIND_POSITION, 0, 0, 0, 1'b1, 1'b1);
			return;
		end
		sa_step = (vert * full_turn * 2 + prec) / (2 * prec);
		sb_step = (ring * full_turn * 2 + prec) / (2 * prec);
		sa = sine_of(sa_step);
		ca = sine_of(sa_step + SINE_TABLE_DEPTH);
		sb = sine_of(sb_step);
		cb = sine_of(sb_step + SINE_TABLE_DEPTH);
		p = longint'(cur_major) + qmul(longint'(cur_tube), ca);
		add_attr(tvag_pkg::KIND_POSITION, qmul(p, cb), qmul(longint'(cur_tube), sa),
			-qmul(p, sb), 1'b0, 1'b0);
		add_attr(tvag_pkg::KIND_NORMAL, qmul(ca, cb), sa, -qmul(ca, sb), 1'b0, 1'b0);
		add_attr(tvag_pkg::KIND_S_TANGENT, -sb, 0, -cb, 1'b0, 1'b0);
		add_attr(tvag_pkg::KIND_T_TANGENT, qmul(sa, cb), -ca, -qmul(sa, sb), 1'b0, 1'b0);
		if (2 * ring > prec)
			ts = ((2 * ring - prec) * one * 2 + prec) / (2 * prec);
		else
			ts = (2 * ring * one * 2 + prec) / (2 * prec);
		tt = (vert * one * 2 + prec) / (2 * prec);
		add_attr(tvag_pkg::KIND_TEXCOORD, ts, tt, 0, 1'b1, 1'b0);
	endfunction

	// Request driver: pops pending requests, predicts them on acceptance.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			push <= 1'b0;
			ring_index <= '0;
			vertex_index <= '0;
		end else begin
			if (push && !full) predict_vertex('{ring_index, vertex_index});
			if (!push || !full) begin
				if (pending_reqs.size() > 0 && !feed_paused
						&& (idle_free || $urandom_range(99) >= 18)) begin
					vertex_req_t rq;
					rq = pending_reqs.pop_front();
					push <= 1'b1;
					ring_index <= rq.ring;
					vertex_index <= rq.vert;
				end else begin
					push <= 1'b0;
				end
			end
		end
	end

	// Result monitor with random back pressure.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pop <= 1'b0;
		end else begin
			if (pop && !empty) begin
				if (expected_attrs.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) $display("Unexpected item kind %0d", attribute_kind);
				end else begin
					attr_item_t e;
					e = expected_attrs.pop_front();
					if (attribute_kind !== e.kind || value_x !== e.x || value_y !== e.y
							|| value_z !== e.z || last_of_vertex !== e.last
							|| index_error !== e.err) begin
						mismatches++;
						if (mismatches <= 10)
							$display("Mismatch exp k%0d %0d %0d %0d l%b e%b got k%0d %0d %0d %0d l%b e%b",
								e.kind, e.x, e.y, e.z, e.last, e.err, attribute_kind,
								value_x, value_y, value_z, last_of_vertex, index_error);
					end
				end
			end
			pop <= idle_free || ($urandom_range(99) >= 18);
		end
	end

	task automatic reg_write(logic [1:0] idx, logic [31:0] val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			tvag_pkg::REG_POINT_COUNT: cur_points = val[7:0];
			tvag_pkg::REG_MAJOR_RADIUS: cur_major = val[15:0];
			default: cur_tube = val[15:0];
		endcase
	endtask

	task automatic drain_all();
		while (pending_reqs.size() > 0 || push || expected_attrs.size() > 0)
			@(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	task automatic add_req(int r, int v);
		pending_reqs.push_back('{r[7:0], v[7:0]});
	endtask

	// Mostly in-range indexes, with some out of range.
	task automatic add_random(int n);
		int p;
		for (int i = 0; i < n; i++) begin
			p = cur_points;
			if ($urandom_range(9) == 0 || p == 0)
				add_req($urandom_range(255), $urandom_range(255));
			else
				add_req($urandom_range(p), $urandom_range(p));
		end
	endtask

	initial begin
		psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
		arst_n = 0;
		cur_points = tvag_pkg::POINT_COUNT_RESET;
		cur_major = tvag_pkg::MAJOR_RADIUS_RESET;
		cur_tube = tvag_pkg::TUBE_RADIUS_RESET;
		build_sine();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: corners, quarter turns, half-turn texcoord, out-of-range indexes.
		add_req(0, 0); add_req(48, 48); add_req(12, 36); add_req(24, 24);
		add_req(25, 1); add_req(49, 0); add_req(0, 49); add_req(255, 255);
		add_req(47, 13);
		drain_all();
		// Largest radii; largest segment count of 255.
		reg_write(tvag_pkg::REG_POINT_COUNT, 255);
		reg_write(tvag_pkg::REG_MAJOR_RADIUS, 32'hFFFF);
		reg_write(tvag_pkg::REG_TUBE_RADIUS, 32'hFFFF);
		add_req(0, 0); add_req(255, 255); add_req(128, 170); add_req(85, 64);
		add_random(30);
		drain_all();
		// Zero segment count makes every request an error.
		reg_write(tvag_pkg::REG_POINT_COUNT, 0);
		add_req(0, 0); add_req(170, 85);
		drain_all();
		reg_write(tvag_pkg::REG_POINT_COUNT, 1);
		reg_write(tvag_pkg::REG_MAJOR_RADIUS, 0);
		reg_write(tvag_pkg::REG_TUBE_RADIUS, 0);
		add_req(0, 0); add_req(1, 1); add_req(1, 0); add_req(2, 1);
		drain_all();
		// Random phases with a stretch of no idling.
		reg_write(tvag_pkg::REG_POINT_COUNT, 48);
		reg_write(tvag_pkg::REG_MAJOR_RADIUS, 8192);
		reg_write(tvag_pkg::REG_TUBE_RADIUS, 3277);
		idle_free = 1;
		add_random(60);
		drain_all();
		idle_free = 0;
		reg_write(tvag_pkg::REG_POINT_COUNT, $urandom_range(2, 254));
		reg_write(tvag_pkg::REG_MAJOR_RADIUS, $urandom_range(65535));
		reg_write(tvag_pkg::REG_TUBE_RADIUS, $urandom_range(65535));
		add_random(60);
		// Hold the feed until every expected item is out.
		while (pending_reqs.size() > 0) @(posedge clk);
		feed_paused = 1;
		add_random(40);
		@(posedge clk);
		while (push || expected_attrs.size() > 0) @(posedge clk);
		feed_paused = 0;
		drain_all();
		reg_write(tvag_pkg::REG_POINT_COUNT, 3);
		reg_write(tvag_pkg::REG_MAJOR_RADIUS, $urandom_range(65535));
		reg_write(tvag_pkg::REG_TUBE_RADIUS, $urandom_range(65535));
		add_random(60);
		drain_all();

		if (mismatches == 0 && expected_attrs.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end
endmodule
